>>> rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg - shared types and constants for the perspective texture mapper
// Field widths, register codes, coverage codes and texel result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

    localparam int ROW_W  = 8;
    localparam int COL_W  = 9;
    localparam int COV_W  = 2;
    localparam int TCOL_W = 9;
    localparam int TROW_W = 8;

    localparam int VTX_W   = 48;
    localparam int REG_NUM = 6;
    localparam int IDX_W   = 3;

    localparam int CRD_W = 16;             // x, y Q11.4 and depth Q7.8
    localparam int DIF_W = CRD_W + 1;      // coordinate differences
    localparam int PRD_W = 2 * DIF_W;      // edge products
    localparam int EW    = PRD_W + 3;      // edge values and area, signed
    localparam int FRAC  = 16;             // barycentric weights Q0.16
    localparam int BW    = FRAC + 1;       // weight can reach 1.0
    localparam int ZZ_W  = 2 * CRD_W;      // depth products
    localparam int WW    = BW + 1 + ZZ_W;  // perspective weights, signed
    localparam int SW    = WW + 2;         // weight sums, signed
    localparam int SM_W  = SW - 1;         // sum magnitude

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;

    typedef enum logic [IDX_W-1:0] {
        REG_A_V0 = 3'd0,
        REG_A_V1 = 3'd1,
        REG_A_V2 = 3'd2,
        REG_B_V0 = 3'd3,
        REG_B_V1 = 3'd4,
        REG_B_V2 = 3'd5
    } reg_idx_t;

    typedef enum logic [COV_W-1:0] {
        COV_NONE = 2'd0,
        COV_A    = 2'd1,
        COV_B    = 2'd2
    } cov_t;

    typedef enum logic [1:0] {
        TEX_ZERO = 2'd0,
        TEX_MAX  = 2'd1,
        TEX_DIV  = 2'd2
    } tex_kind_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        cov_t             cov;
    } pix_tag_t;

    typedef struct packed {
        pix_tag_t  pix;
        tex_kind_t kind_col;
        tex_kind_t kind_row;
    } tex_tag_t;

    function automatic logic signed [DIF_W-1:0] sx(input logic [CRD_W-1:0] v);
        sx = $signed({v[CRD_W-1], v});
    endfunction

endpackage

`default_nettype wire

>>> rtl/ptm_div.sv
// ----------------------------------------------------------------------------
// ptm_div - pipelined restoring divider
// One quotient bit per stage for several dividends sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_div #(
    parameter int QW    = 17,
    parameter int DENW  = 37,
    parameter int LANES = 3,
    parameter int TAGW  = 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic [LANES-1:0][DENW-1:0]       in_hi,
    input  wire logic [LANES-1:0][QW-1:0]         in_lo,
    input  wire logic [DENW-1:0]                  in_den,
    input  wire logic [TAGW-1:0]                  in_tag,
    output logic                                  out_valid,
    output logic [LANES-1:0][QW-1:0]              out_q,
    output logic [TAGW-1:0]                       out_tag
);

    logic [QW-1:0]                valid_reg;
    logic [LANES-1:0][DENW-1:0]   rem_reg [QW];
    logic [LANES-1:0][QW-1:0]     lo_reg  [QW];
    logic [LANES-1:0][QW-1:0]     q_reg   [QW];
    logic [DENW-1:0]              den_reg [QW];
    logic [TAGW-1:0]              tag_reg [QW];

    genvar g, l;
    for (g = 0; g < QW; g++)
    begin : g_step
        logic                       src_valid;
        logic [LANES-1:0][DENW-1:0] src_rem;
        logic [LANES-1:0][QW-1:0]   src_lo;
        logic [LANES-1:0][QW-1:0]   src_q;
        logic [DENW-1:0]            src_den;
        logic [TAGW-1:0]            src_tag;
        logic [LANES-1:0][DENW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0]   lo_next;
        logic [LANES-1:0][QW-1:0]   q_next;

        if (g == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = in_hi;
            assign src_lo    = in_lo;
            assign src_q     = '0;
            assign src_den   = in_den;
            assign src_tag   = in_tag;
        end
        else
        begin : g_later
            assign src_valid = valid_reg[g-1];
            assign src_rem   = rem_reg[g-1];
            assign src_lo    = lo_reg[g-1];
            assign src_q     = q_reg[g-1];
            assign src_den   = den_reg[g-1];
            assign src_tag   = tag_reg[g-1];
        end

        for (l = 0; l < LANES; l++)
        begin : g_lane
            logic [DENW:0] trial;
            logic          ge;
            assign trial       = {src_rem[l], src_lo[l][QW-1]};
            assign ge          = trial >= {1'b0, src_den};
            assign rem_next[l] = ge ? DENW'(trial - {1'b0, src_den}) : DENW'(trial);
            assign lo_next[l]  = {src_lo[l][QW-2:0], 1'b0};
            assign q_next[l]   = {src_q[l][QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                lo_reg[g]  <= lo_next;
                q_reg[g]   <= q_next;
                den_reg[g] <= src_den;
                tag_reg[g] <= src_tag;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

`default_nettype wire

>>> rtl/ptm_edge.sv
// ----------------------------------------------------------------------------
// ptm_edge - edge functions and triangle selection
// Three stages: differences, products, inside test with A before B.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_edge (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire logic [ptm_pkg::ROW_W-1:0]             in_row,
    input  wire logic [ptm_pkg::COL_W-1:0]             in_col,
    input  wire logic [ptm_pkg::REG_NUM-1:0][ptm_pkg::VTX_W-1:0] vtx,
    output logic                                       out_valid,
    output ptm_pkg::pix_tag_t                          out_tag,
    output logic [2:0][ptm_pkg::EW-1:0]                out_mag_e,
    output logic [ptm_pkg::EW-1:0]                     out_mag_d
);
    import ptm_pkg::*;

    // differences per triangle: 0 px-x1, 1 y2-y1, 2 py-y1, 3 x2-x1, 4 px-x2,
    // 5 y0-y2, 6 py-y2, 7 x0-x2, 8 x0-x1, 9 y0-y1
    logic signed [DIF_W-1:0] dif_reg [2][10];
    logic signed [EW-1:0]    d_reg   [2];
    logic signed [EW-1:0]    e0_reg  [2];
    logic signed [EW-1:0]    e1_reg  [2];
    logic [2:0]              valid_reg;
    pix_tag_t                tag1_reg, tag2_reg, tag3_reg;
    logic [2:0][EW-1:0]      mag_e_reg;
    logic [EW-1:0]           mag_d_reg;

    logic signed [DIF_W-1:0] px, py;
    logic signed [DIF_W-1:0] xv [2][3];
    logic signed [DIF_W-1:0] yv [2][3];

    assign px = $signed({4'b0, in_col, 4'b0});
    assign py = $signed({5'b0, in_row, 4'b0});

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                xv[t][k] = sx(vtx[3*t+k][47:32]);
                yv[t][k] = sx(vtx[3*t+k][31:16]);
            end
        end
    end

    // stage 3 logic
    logic signed [EW-1:0] e2    [2];
    logic                 tri_hit [2];
    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            e2[t] = d_reg[t] - e0_reg[t] - e1_reg[t];
            if (d_reg[t] == '0)
            begin
                tri_hit[t] = 1'b0;
            end
            else if (d_reg[t] > 0)
            begin
                tri_hit[t] = !e0_reg[t][EW-1] && !e1_reg[t][EW-1] && !e2[t][EW-1];
            end
            else
            begin
                tri_hit[t] = (e0_reg[t] <= 0) && (e1_reg[t] <= 0) && (e2[t] <= 0);
            end
        end
    end

    function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
        mag = v[EW-1] ? EW'(-v) : EW'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 2; t++)
            begin
                dif_reg[t][0] <= px - xv[t][1];
                dif_reg[t][1] <= yv[t][2] - yv[t][1];
                dif_reg[t][2] <= py - yv[t][1];
                dif_reg[t][3] <= xv[t][2] - xv[t][1];
                dif_reg[t][4] <= px - xv[t][2];
                dif_reg[t][5] <= yv[t][0] - yv[t][2];
                dif_reg[t][6] <= py - yv[t][2];
                dif_reg[t][7] <= xv[t][0] - xv[t][2];
                dif_reg[t][8] <= xv[t][0] - xv[t][1];
                dif_reg[t][9] <= yv[t][0] - yv[t][1];

                d_reg[t]  <= EW'(dif_reg[t][9] * dif_reg[t][3])
                           - EW'(dif_reg[t][8] * dif_reg[t][1]);
                e0_reg[t] <= EW'(dif_reg[t][2] * dif_reg[t][3])
                           - EW'(dif_reg[t][0] * dif_reg[t][1]);
                e1_reg[t] <= EW'(dif_reg[t][6] * dif_reg[t][7])
                           - EW'(dif_reg[t][4] * dif_reg[t][5]);
            end
            tag1_reg.row <= in_row;
            tag1_reg.col <= in_col;
            tag1_reg.cov <= COV_NONE;
            tag2_reg     <= tag1_reg;

            tag3_reg <= tag2_reg;
            if (tri_hit[0])
            begin
                tag3_reg.cov <= COV_A;
                mag_e_reg    <= {mag(e2[0]), mag(e1_reg[0]), mag(e0_reg[0])};
                mag_d_reg    <= mag(d_reg[0]);
            end
            else
            begin
                tag3_reg.cov <= tri_hit[1] ? COV_B : COV_NONE;
                mag_e_reg    <= {mag(e2[1]), mag(e1_reg[1]), mag(e0_reg[1])};
                mag_d_reg    <= mag(d_reg[1]);
            end
        end
    end

    assign out_valid = valid_reg[2];
    assign out_tag   = tag3_reg;
    assign out_mag_e = mag_e_reg;
    assign out_mag_d = mag_d_reg;

endmodule

`default_nettype wire

>>> rtl/ptm_persp.sv
// ----------------------------------------------------------------------------
// ptm_persp - perspective weights and texel scaling
// Depth products, weight products, sums, sign fold and clamp, scale by L-1.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_persp #(
    parameter int SCREEN_WIDTH  = ptm_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ptm_pkg::DEF_SCREEN_HEIGHT,
    parameter int QT            = 9
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire ptm_pkg::pix_tag_t                     in_tag,
    input  wire logic [2:0][ptm_pkg::BW-1:0]           in_b,
    input  wire logic [ptm_pkg::REG_NUM-1:0][ptm_pkg::VTX_W-1:0] vtx,
    output logic                                       out_valid,
    output ptm_pkg::tex_tag_t                          out_tag,
    output logic [1:0][ptm_pkg::SM_W-1:0]              out_hi,
    output logic [1:0][QT-1:0]                         out_lo,
    output logic [ptm_pkg::SM_W-1:0]                   out_den
);
    import ptm_pkg::*;

    localparam logic [QT-1:0] M_COL = QT'(SCREEN_WIDTH - 1);
    localparam logic [QT-1:0] M_ROW = QT'(SCREEN_HEIGHT - 1);
    localparam int XW = SM_W + QT;

    logic [4:0]              valid_reg;
    pix_tag_t                tag1_reg, tag2_reg, tag3_reg;
    tex_tag_t                tag4_reg, tag5_reg;
    logic signed [ZZ_W-1:0]  zz_reg [3];
    logic [BW-1:0]           b1_reg [3];
    logic signed [WW-1:0]    w_reg  [3];
    logic signed [SW-1:0]    s_reg, nu_reg, nv_reg;
    logic [SM_W-1:0]         sm4_reg, sm5_reg;
    logic [SM_W-1:0]         nu4_reg, nv4_reg;
    logic [XW-1:0]           xc_reg, xr_reg;

    logic signed [CRD_W-1:0] zv [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            zv[k] = (in_tag.cov == COV_B) ? $signed(vtx[3+k][15:0])
                                          : $signed(vtx[k][15:0]);
        end
    end

    // sign fold and clamp
    logic                  neg;
    logic signed [SW-1:0]  sp, nup, nvp;
    tex_kind_t             kc, kr;

    function automatic tex_kind_t kind_of(input logic signed [SW-1:0] n,
                                          input logic signed [SW-1:0] s,
                                          input logic               cov_hit);
        tex_kind_t k;
        if (!cov_hit || s == '0 || n <= 0)
        begin
            k = TEX_ZERO;
        end
        else if (n >= s)
        begin
            k = TEX_MAX;
        end
        else
        begin
            k = TEX_DIV;
        end
        return k;
    endfunction

    always_comb
    begin
        neg = s_reg[SW-1];
        sp  = neg ? -s_reg  : s_reg;
        nup = neg ? -nu_reg : nu_reg;
        nvp = neg ? -nv_reg : nv_reg;
        kc  = kind_of(nup, sp, tag3_reg.cov != COV_NONE);
        kr  = kind_of(nvp, sp, tag3_reg.cov != COV_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zz_reg[0] <= zv[1] * zv[2];
            zz_reg[1] <= zv[0] * zv[2];
            zz_reg[2] <= zv[0] * zv[1];
            b1_reg    <= '{in_b[0], in_b[1], in_b[2]};
            tag1_reg  <= in_tag;

            for (int k = 0; k < 3; k++)
            begin
                w_reg[k] <= $signed({1'b0, b1_reg[k]}) * zz_reg[k];
            end
            tag2_reg <= tag1_reg;

            s_reg <= SW'(w_reg[0]) + SW'(w_reg[1]) + SW'(w_reg[2]);
            if (tag2_reg.cov == COV_A)
            begin
                nu_reg <= SW'(w_reg[0]) + SW'(w_reg[2]);
                nv_reg <= SW'(w_reg[1]) + SW'(w_reg[2]);
            end
            else
            begin
                nu_reg <= SW'(w_reg[2]);
                nv_reg <= SW'(w_reg[0]);
            end
            tag3_reg <= tag2_reg;

            sm4_reg           <= SM_W'(sp);
            nu4_reg           <= SM_W'(nup);
            nv4_reg           <= SM_W'(nvp);
            tag4_reg.pix      <= tag3_reg;
            tag4_reg.kind_col <= kc;
            tag4_reg.kind_row <= kr;

            xc_reg   <= nu4_reg * M_COL;
            xr_reg   <= nv4_reg * M_ROW;
            sm5_reg  <= sm4_reg;
            tag5_reg <= tag4_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_tag   = tag5_reg;
    assign out_hi    = {xr_reg[XW-1:QT], xc_reg[XW-1:QT]};
    assign out_lo    = {xr_reg[QT-1:0], xc_reg[QT-1:0]};
    assign out_den   = sm5_reg;

endmodule

`default_nettype wire

>>> rtl/perspective_texture_mapper.sv
// ----------------------------------------------------------------------------
// perspective_texture_mapper - screen pixel to texel lookup for one quad
// Barycentric test against two triangles, perspective-correct u, v, texel.
// ----------------------------------------------------------------------------
//  channel  | direction | transfer carries
//  s_*      | in        | tdata: pixel_row[7:0], pixel_col[16:8]
//  m_*      | out       | tdata: dest_row, dest_col, texel_col, texel_row;
//           |           | tuser: coverage
//  cfg_*    | in        | cfg_index (register 0..5), cfg_data (48 bits)
//
// One pixel per cycle sustained while the skid register is empty. The
// pipeline is made of the edge stages, the weight divider stages, the
// perspective stages, the texel divider stages and an output register.
// Reset clears all valid bits and the vertex registers; no clearing pass.
// A skid register behind the output keeps the pipeline moving while one
// result waits; the pipeline stalls as a whole only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_texture_mapper #(
    parameter int SCREEN_WIDTH  = ptm_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ptm_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,   // pixel_row, pixel_col
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [39:0]                        m_tdata,   // dest_row, dest_col,
                                                          // texel_col, texel_row
    output logic [ptm_pkg::COV_W-1:0]          m_tuser,   // coverage
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ptm_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [ptm_pkg::VTX_W-1:0]     cfg_data
);
    import ptm_pkg::*;

    localparam int QT = $clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH
                                                              : SCREEN_HEIGHT);
    localparam int OUT_W = ROW_W + COL_W + TCOL_W + TROW_W;

    logic [REG_NUM-1:0][VTX_W-1:0] vtx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index) inside
                REG_A_V0, REG_A_V1, REG_A_V2, REG_B_V0, REG_B_V1, REG_B_V2:
                begin
                    vtx_reg[cfg_index] <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic en;

    // edge stage
    logic               e_valid;
    pix_tag_t           e_tag;
    logic [2:0][EW-1:0] e_mag;
    logic [EW-1:0]      d_mag;

    ptm_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_row    (s_tdata[7:0]),
        .in_col    (s_tdata[16:8]),
        .vtx       (vtx_reg),
        .out_valid (e_valid),
        .out_tag   (e_tag),
        .out_mag_e (e_mag),
        .out_mag_d (d_mag)
    );

    // barycentric weights |e|*2^16/|d|
    logic [2:0][EW-1:0] b_hi;
    logic [2:0][BW-1:0] b_lo;
    logic               b_valid;
    logic [2:0][BW-1:0] b_q;
    logic [$bits(pix_tag_t)-1:0] b_tag;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            b_hi[k] = {1'b0, e_mag[k][EW-1:1]};
            b_lo[k] = {e_mag[k][0], {FRAC{1'b0}}};
        end
    end

    ptm_div #(
        .QW    (BW),
        .DENW  (EW),
        .LANES (3),
        .TAGW  ($bits(pix_tag_t))
    ) u_bdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid),
        .in_hi     (b_hi),
        .in_lo     (b_lo),
        .in_den    (d_mag),
        .in_tag    (e_tag),
        .out_valid (b_valid),
        .out_q     (b_q),
        .out_tag   (b_tag)
    );

    // perspective and scaling
    logic                 p_valid;
    tex_tag_t             p_tag;
    logic [1:0][SM_W-1:0] p_hi;
    logic [1:0][QT-1:0]   p_lo;
    logic [SM_W-1:0]      p_den;

    ptm_persp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .QT            (QT)
    ) u_persp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid),
        .in_tag    (pix_tag_t'(b_tag)),
        .in_b      (b_q),
        .vtx       (vtx_reg),
        .out_valid (p_valid),
        .out_tag   (p_tag),
        .out_hi    (p_hi),
        .out_lo    (p_lo),
        .out_den   (p_den)
    );

    // texel index N*(L-1)/S
    logic                        t_valid;
    logic [1:0][QT-1:0]          t_q;
    logic [$bits(tex_tag_t)-1:0] t_tag_bits;
    tex_tag_t                    t_tag;

    ptm_div #(
        .QW    (QT),
        .DENW  (SM_W),
        .LANES (2),
        .TAGW  ($bits(tex_tag_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid),
        .in_hi     (p_hi),
        .in_lo     (p_lo),
        .in_den    (p_den),
        .in_tag    (p_tag),
        .out_valid (t_valid),
        .out_q     (t_q),
        .out_tag   (t_tag_bits)
    );

    assign t_tag = tex_tag_t'(t_tag_bits);

    logic [TCOL_W-1:0] tcol;
    logic [TROW_W-1:0] trow;

    always_comb
    begin
        case (t_tag.kind_col)
            TEX_MAX: tcol = TCOL_W'(SCREEN_WIDTH - 1);
            TEX_DIV: tcol = TCOL_W'(t_q[0]);
            default: tcol = '0;
        endcase
        case (t_tag.kind_row)
            TEX_MAX: trow = TROW_W'(SCREEN_HEIGHT - 1);
            TEX_DIV: trow = TROW_W'(t_q[1]);
            default: trow = '0;
        endcase
    end

    logic [OUT_W-1:0] last_data;
    assign last_data = {trow, tcol, t_tag.pix.col, t_tag.pix.row};

    // output register with skid
    logic             out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;
    cov_t             out_cov_reg, skid_cov_reg;
    logic             push;

    assign en   = !skid_valid_reg;
    assign push = en && t_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : last_data;
            out_cov_reg  <= skid_valid_reg ? skid_cov_reg  : t_tag.pix.cov;
        end
        else if (push)
        begin
            skid_data_reg <= last_data;
            skid_cov_reg  <= t_tag.pix.cov;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(40 - OUT_W)'(0), out_data_reg};
    assign m_tuser  = out_cov_reg;

endmodule

`default_nettype wire

>>> test/perspective_texture_mapper_tb.sv
// ----------------------------------------------------------------------------
// perspective_texture_mapper_tb - self-checking bench for the texture mapper
// Streams screen pixels against programmed quads and checks the coverage and
// texel of every result against a predictor held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_texture_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptm_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE7 = 3'd7;
    localparam int  TEX_W      = DEF_SCREEN_WIDTH;
    localparam int  TEX_H      = DEF_SCREEN_HEIGHT;
    localparam int  DRAIN      = 60;
    localparam longint CYCLE_LIMIT = 1_500_000;

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        cov_t              cov;
        logic [TCOL_W-1:0] tcol;
        logic [TROW_W-1:0] trow;
    } texel_hit_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic [COV_W-1:0]     m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [VTX_W-1:0]     cfg_data = '0;

    logic [VTX_W-1:0]     vertex_regs [REG_NUM];
    texel_hit_t           pending_texels [$];
    int                   send_idle_pct = 0;
    int                   sink_stall_pct = 0;
    logic                 sink_hold = 1'b0;
    int                   mismatches = 0;
    longint               cycles = 0;

    perspective_texture_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL perspective_texture_mapper");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // ---- predictor ---------------------------------------------------------

    function automatic longint field16(logic [VTX_W-1:0] r, int lsb);
        logic signed [CRD_W-1:0] f;
        f = r[lsb +: CRD_W];
        return longint'(f);
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // point test against one triangle; perspective weights out when inside
    function automatic bit tri_weights(int base, longint px, longint py,
                                       output longint w [3]);
        longint x [3], y [3], z [3], e [3], b [3], area;
        for (int k = 0; k < 3; k++)
        begin
            x[k] = field16(vertex_regs[base + k], 32);
            y[k] = field16(vertex_regs[base + k], 16);
            z[k] = field16(vertex_regs[base + k], 0);
        end
        w = '{0, 0, 0};
        area = -(x[0] - x[1]) * (y[2] - y[1]) + (y[0] - y[1]) * (x[2] - x[1]);
        if (area == 0)
            return 1'b0;
        e[0] = -(px - x[1]) * (y[2] - y[1]) + (py - y[1]) * (x[2] - x[1]);
        e[1] = -(px - x[2]) * (y[0] - y[2]) + (py - y[2]) * (x[0] - x[2]);
        e[2] = area - e[0] - e[1];
        for (int k = 0; k < 3; k++)
            if ((area > 0 && e[k] < 0) || (area < 0 && e[k] > 0))
                return 1'b0;
        for (int k = 0; k < 3; k++)
            b[k] = (abs64(e[k]) * 65536) / abs64(area);
        w[0] = b[0] * z[1] * z[2];
        w[1] = b[1] * z[0] * z[2];
        w[2] = b[2] * z[0] * z[1];
        return 1'b1;
    endfunction

    function automatic longint texel_index(longint n, longint s, longint len);
        if (s == 0)
            return 0;
        if (s < 0)
        begin
            n = -n;
            s = -s;
        end
        if (n <= 0)
            return 0;
        if (n >= s)
            return len - 1;
        return (n * (len - 1)) / s;
    endfunction

    function automatic texel_hit_t shade_pixel(logic [ROW_W-1:0] row,
                                               logic [COL_W-1:0] col);
        texel_hit_t r;
        longint w [3], nu, nv, s;
        r.row = row;
        r.col = col;
        r.cov = COV_NONE;
        r.tcol = '0;
        r.trow = '0;
        if (tri_weights(0, longint'(col) * 16, longint'(row) * 16, w))
        begin
            r.cov = COV_A;
            nu = w[0] + w[2];
            nv = w[1] + w[2];
        end
        else if (tri_weights(3, longint'(col) * 16, longint'(row) * 16, w))
        begin
            r.cov = COV_B;
            nu = w[2];
            nv = w[0];
        end
        if (r.cov != COV_NONE)
        begin
            s = w[0] + w[1] + w[2];
            r.tcol = TCOL_W'(texel_index(nu, s, TEX_W));
            r.trow = TROW_W'(texel_index(nv, s, TEX_H));
        end
        return r;
    endfunction

    // ---- result checker ----------------------------------------------------

    always @(posedge clk)
    begin
        texel_hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_texels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer tdata=%h tuser=%h", m_tdata, m_tuser);
            end
            else
            begin
                want = pending_texels.pop_front();
                if (m_tdata[7:0] !== want.row || m_tdata[16:8] !== want.col
                    || m_tuser !== want.cov || m_tdata[25:17] !== want.tcol
                    || m_tdata[33:26] !== want.trow || m_tdata[39:34] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch pix(%0d,%0d): exp cov %0d tex(%0d,%0d) got %h/%0d",
                                 want.row, want.col, want.cov, want.tcol, want.trow,
                                 m_tdata, m_tuser);
                end
            end
        end
    end

    // ---- drivers -----------------------------------------------------------

    task automatic send_pixel(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_texels.push_back(shade_pixel(row, col));
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_texels.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_vertex(logic [IDX_W-1:0] idx, logic [VTX_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx < REG_NUM)
            vertex_regs[idx] = val;
        @(posedge clk);
    endtask

    function automatic logic [VTX_W-1:0] vtx(int x, int y, int z);
        return {16'(x), 16'(y), 16'(z)};
    endfunction

    // texture-aligned quad spanning the screen
    task automatic load_screen_quad(int z0, int z1, int z2, int z3);
        write_vertex(REG_A_V0, vtx(319 * 16, 0, z1));
        write_vertex(REG_A_V1, vtx(0, 239 * 16, z2));
        write_vertex(REG_A_V2, vtx(319 * 16, 239 * 16, z3));
        write_vertex(REG_B_V0, vtx(0, 239 * 16, z2));
        write_vertex(REG_B_V1, vtx(0, 0, z0));
        write_vertex(REG_B_V2, vtx(319 * 16, 0, z1));
    endtask

    // mode 0 positive depth, positions up to 340x260, 1 any bits, 2 mixed/zero depth
    task automatic load_random_quad(int mode);
        for (int k = 0; k < REG_NUM; k++)
        begin
            logic [VTX_W-1:0] val;
            case (mode)
                0: val = vtx($urandom_range(0, 340 * 16), $urandom_range(0, 260 * 16),
                             $urandom_range(1, 32767));
                1: val = VTX_W'({$urandom, $urandom});
                default: val = vtx($urandom_range(0, 320 * 16), $urandom_range(0, 240 * 16),
                                   $urandom_range(0, 3) == 0 ? 0 : $urandom);
            endcase
            write_vertex(reg_idx_t'(k), val);
        end
    endtask

    task automatic send_random_pixels(int count);
        for (int i = 0; i < count; i++)
            if ($urandom_range(9) == 0)
                send_pixel(ROW_W'($urandom), COL_W'($urandom));
            else
                send_pixel(ROW_W'($urandom_range(0, 239)), COL_W'($urandom_range(0, 319)));
    endtask

    // ---- tests -------------------------------------------------------------

    task automatic test_reset_black();
        send_pixel(0, 0);
        send_pixel(8'hFF, 9'h1FF);
        drain_results();
    endtask

    task automatic test_directed_quad();
        load_screen_quad(256, 256, 256, 256);
        send_pixel(0, 0);
        send_pixel(0, 319);
        send_pixel(239, 0);
        send_pixel(239, 319);
        send_pixel(120, 160);
        send_pixel(100, 100);
        send_pixel(255, 511);     // off screen
        send_pixel(240, 320);
        drain_results();
        load_screen_quad(16'h7FFF, 256, 64, 16'h8000);
        send_pixel(60, 60);
        send_pixel(200, 250);
        send_pixel(119, 159);
        drain_results();
    endtask

    task automatic test_special_cases();
        // depth zero: covered, but weight sum vanishes
        load_screen_quad(0, 0, 0, 0);
        send_pixel(50, 50);
        send_pixel(200, 300);
        drain_results();
        // collapsed A (zero area) so B alone decides; spare indexes dropped
        write_vertex(REG_A_V0, vtx(0, 0, 256));
        write_vertex(REG_A_V1, vtx(0, 0, 256));
        write_vertex(REG_A_V2, vtx(0, 0, 256));
        write_vertex(REG_SPARE6, {VTX_W{1'b1}});
        write_vertex(REG_SPARE7, {VTX_W{1'b1}});
        send_pixel(10, 10);
        send_pixel(230, 300);
        drain_results();
        // overlapping triangles sharing two vertices, A must win; field extremes
        write_vertex(REG_A_V0, vtx(16'h8000, 16'h8000, 16'h7FFF));
        write_vertex(REG_A_V1, vtx(16'h7FFF, 16'h8000, 16'h8000));
        write_vertex(REG_A_V2, vtx(0, 16'h7FFF, 16'hFFFF));
        write_vertex(REG_B_V0, vtx(16'h8000, 16'h8000, 16'h7FFF));
        write_vertex(REG_B_V1, vtx(16'h7FFF, 16'h8000, 16'h8000));
        write_vertex(REG_B_V2, {VTX_W{1'b1}});
        send_pixel(0, 0);
        send_pixel(8'hFF, 9'h1FF);
        send_pixel(8'h55, 9'h0AA);
        send_pixel(8'hAA, 9'h155);
        drain_results();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        for (int mode = 0; mode < 3; mode++)
        begin
            load_random_quad(mode);
            send_random_pixels(mode == 0 ? count / 2 : count / 4);
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        load_random_quad(0);
        fork
            begin
                sink_hold <= 1'b1;
                repeat (300) @(posedge clk);
                sink_hold <= 1'b0;
            end
            send_random_pixels(120);
        join
        drain_results();
    endtask

    initial
    begin
        for (int k = 0; k < REG_NUM; k++)
            vertex_regs[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_black();
        test_directed_quad();
        test_special_cases();
        test_random_phase(0, 0, 300);
        test_random_phase(85, 0, 240);
        test_random_phase(0, 85, 240);
        test_random_phase(17, 17, 300);
        test_backpressure();
        test_random_phase(0, 0, 200);
        if (mismatches == 0 && pending_texels.size() == 0)
            $display("PASS perspective_texture_mapper");
        else
            $display("FAIL perspective_texture_mapper");
        $finish;
    end

endmodule

`default_nettype wire
